/* rtl/cpb_pkg.sv */
// Shared types, constants and arithmetic helpers for the countdown progress bar pixel block.
// Used by cpb_colour, countdown_progress_bar_pixel, cpb_checker and tb_top; depends on nothing else.
package cpb_pkg;

    localparam int unsigned MAX_PIXELS   = 255;
    localparam int unsigned PRE_MS       = 10000;
    localparam int unsigned BLINK_MS     = 500;
    localparam int unsigned SEC_MS       = 1000;
    localparam int unsigned DEF_SECONDS  = 60;
    localparam int unsigned MIN_PIXELS   = 4;
    localparam int unsigned PRE_SECONDS  = PRE_MS / SEC_MS;

    localparam int unsigned TOT_W = 22;   // duration in ms, up to 4 095 000
    localparam int unsigned ACC_W = 30;   // product of a TOT_W value and a pixel count
    localparam int unsigned LEN_W = 8;

    // pipeline stage map
    localparam int ST_CAP  = 0;
    localparam int ST_PRE  = 1;
    localparam int ST_MUL1 = 2;
    localparam int ST_D1   = 3;                 // 8 steps: lit count
    localparam int ST_R1   = ST_D1 + 8;
    localparam int ST_D2   = ST_R1 + 1;         // 20 steps: remainder by strip length
    localparam int ST_SUB  = ST_D2 + 20;
    localparam int ST_MUL2 = ST_SUB + 1;
    localparam int ST_D3   = ST_MUL2 + 1;       // 8 steps: marker offset
    localparam int ST_LAST = ST_D3 + 7;         // last stage held in the top level
    localparam int ST_OUT  = ST_LAST + 1;       // colour output register

    typedef enum logic [0:0] {
        CFG_DURATION = 1'b0,
        CFG_LENGTH   = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_BLINK = 2'd0,
        PH_BAR   = 2'd1,
        PH_DONE  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [31:0]        elapsed;
        logic [LEN_W-1:0]   px;
        logic               pre;
        logic               blink;
        logic               fin;
        logic [TOT_W-1:0]   t;
        logic [ACC_W-1:0]   acc;
        logic [LEN_W-1:0]   lit;
        logic [TOT_W-1:0]   r1;
        logic [LEN_W-1:0]   q3;
    } t_stage;

    typedef struct packed {
        logic             hit;
        logic [ACC_W-1:0] rem;
    } t_div;

    // One restoring division step: subtract d << k when it fits.
    function automatic t_div div_step(input logic [ACC_W-1:0] acc,
                                      input logic [TOT_W-1:0] d, input int k);
        t_div             r;
        logic [ACC_W:0]   dsh;
        logic [ACC_W:0]   a;
        dsh   = (ACC_W+1)'(d) << k;
        a     = {1'b0, acc};
        r.hit = (a >= dsh);
        r.rem = r.hit ? ACC_W'(a - dsh) : acc;
        return r;
    endfunction

    // High during the first half of each second of the pre-countdown.
    function automatic logic blink_on(input logic [31:0] e);
        logic b;
        b = 1'b0;
        for (int k = 0; k < PRE_SECONDS; k++) begin
            if (e >= 32'(k * SEC_MS) && e < 32'(k * SEC_MS + BLINK_MS))
                b = 1'b1;
        end
        return b;
    endfunction

endpackage

/* rtl/countdown_progress_bar_pixel.sv */
// Countdown progress bar pixel: computes one LED pixel's RGBW colour per unstalled clock.
// Depends on cpb_pkg and cpb_colour.
//
// Input channel: i_in_valid / o_in_ready carry elapsed_ms and pixel_index. Output channel:
// o_out_valid / i_out_ready carry red, green, blue, white and phase. Configuration: write
// channel i_cfg_valid / o_cfg_ready with i_cfg_index (0 duration, 1 strip length) and
// i_cfg_data; always ready. The user must see that it is written only while the pipeline
// is empty; the block does not enforce it. Pipeline: 43 register stages, the first loaded
// at the input accept edge. Throughput: one pixel per cycle unless the output stalls.
// The count comes from three restoring dividers done one quotient bit per stage: lit count
// (8 stages), remainder by strip length (20 stages) and marker offset (8 stages), plus
// capture, phase decode, two multiplies, the remainder pick-up and subtract stages and the
// colour register.
// Stalls: the whole pipeline holds while the result waits; o_in_ready drops only then, so a
// new pixel is taken in the same cycle the previous result leaves.
// Reset empties the pipeline and sets duration 60 s and strip length 60.
module countdown_progress_bar_pixel (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_elapsed_ms,
    input  logic [7:0]  i_pixel_index,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_white,
    output logic [1:0]  o_phase,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [11:0] i_cfg_data
);
    import cpb_pkg::*;

    logic [TOT_W-1:0] r_total;
    logic [LEN_W-1:0] r_len;
    logic [TOT_W-1:0] n_total;
    logic [LEN_W-1:0] n_len;
    logic [11:0]      secs;

    t_stage r_st [0:ST_LAST];
    t_stage n_st [0:ST_LAST];
    logic   r_v  [0:ST_OUT];
    logic   en;

    assign o_cfg_ready = 1'b1;

    // duration and strip length are stored already expanded and clamped
    assign secs    = (i_cfg_data == 12'd0) ? 12'(DEF_SECONDS) : i_cfg_data;
    assign n_total = TOT_W'({10'd0, secs} * 22'(SEC_MS));
    assign n_len   = (i_cfg_data[7:0] < 8'(MIN_PIXELS)) ? 8'(MIN_PIXELS) : i_cfg_data[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= TOT_W'(DEF_SECONDS * SEC_MS);
            r_len   <= 8'(DEF_SECONDS);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DURATION: r_total <= n_total;
                CFG_LENGTH:   r_len   <= n_len;
                default:      r_len   <= r_len;
            endcase
        end
    end

    // advance everything unless the result is stuck
    assign en         = !r_v[ST_OUT] || i_out_ready;
    assign o_in_ready = en;

    always_comb begin
        n_st[ST_CAP]         = '0;
        n_st[ST_CAP].elapsed = i_elapsed_ms;
        n_st[ST_CAP].px      = i_pixel_index;
    end

    genvar s;
    generate
        for (s = 1; s <= ST_LAST; s++) begin : g_stage
            if (s == ST_PRE) begin : g_pre
                logic [31:0] t32;
                assign t32 = r_st[s-1].elapsed - 32'(PRE_MS);
                always_comb begin
                    n_st[s]       = r_st[s-1];
                    n_st[s].pre   = r_st[s-1].elapsed < 32'(PRE_MS);
                    n_st[s].blink = blink_on(r_st[s-1].elapsed);
                    n_st[s].fin   = !n_st[s].pre && (t32 >= 32'(r_total));
                    n_st[s].t     = t32[TOT_W-1:0];
                end
            end else if (s == ST_MUL1) begin : g_mul1
                always_comb begin
                    n_st[s]     = r_st[s-1];
                    n_st[s].acc = {8'd0, r_st[s-1].t} * {22'd0, r_len};
                end
            end else if (s >= ST_D1 && s < ST_R1) begin : g_d1
                t_div d;
                assign d = div_step(r_st[s-1].acc, r_total, ST_R1 - 1 - s);
                always_comb begin
                    n_st[s]                     = r_st[s-1];
                    n_st[s].acc                 = d.rem;
                    n_st[s].lit[ST_R1 - 1 - s]  = d.hit;
                end
            end else if (s == ST_R1) begin : g_r1
                always_comb begin
                    n_st[s]    = r_st[s-1];
                    n_st[s].r1 = r_st[s-1].acc[TOT_W-1:0];
                end
            end else if (s >= ST_D2 && s < ST_SUB) begin : g_d2
                t_div d;
                assign d = div_step(r_st[s-1].acc, {14'd0, r_len}, ST_SUB - 1 - s);
                always_comb begin
                    n_st[s]     = r_st[s-1];
                    n_st[s].acc = d.rem;
                end
            end else if (s == ST_SUB) begin : g_sub
                // rest * length equals r1 minus its remainder by length
                always_comb begin
                    n_st[s]     = r_st[s-1];
                    n_st[s].acc = {8'd0, r_st[s-1].r1 - r_st[s-1].acc[TOT_W-1:0]};
                end
            end else if (s == ST_MUL2) begin : g_mul2
                logic [LEN_W-1:0] dark;
                assign dark = r_len - r_st[s-1].lit;
                always_comb begin
                    n_st[s]     = r_st[s-1];
                    n_st[s].acc = {8'd0, r_st[s-1].acc[TOT_W-1:0]} * {22'd0, dark};
                end
            end else begin : g_d3
                t_div d;
                assign d = div_step(r_st[s-1].acc, r_total, ST_LAST - s);
                always_comb begin
                    n_st[s]                  = r_st[s-1];
                    n_st[s].acc              = d.rem;
                    n_st[s].q3[ST_LAST - s]  = d.hit;
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k <= ST_LAST; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= ST_OUT; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_v[0] <= i_in_valid;
            for (int k = 1; k <= ST_OUT; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    cpb_colour u_colour (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_st    (r_st[ST_LAST]),
        .i_len   (r_len),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue),
        .o_white (o_white),
        .o_phase (o_phase)
    );

    assign o_out_valid = r_v[ST_OUT];

    a_done_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_phase == PH_DONE) |->
        (o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0 && o_white == 8'd0))
        else $error("finished pixel carries colour");

    a_lit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[ST_R1] && !r_st[ST_R1].pre && !r_st[ST_R1].fin) |->
        (r_st[ST_R1].lit < r_len && r_st[ST_R1].acc < 30'(r_total)))
        else $error("lit count or remainder out of range");

    a_marker_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[ST_LAST] && !r_st[ST_LAST].pre && !r_st[ST_LAST].fin) |->
        (r_st[ST_LAST].q3 < r_len - r_st[ST_LAST].lit))
        else $error("marker falls inside the bar");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (r_v[ST_LAST] == $past(r_v[ST_LAST])))
        else $error("pipeline moved during stall");

endmodule

/* rtl/cpb_colour.sv */
// Output stage of the countdown progress bar pixel: picks the colour and phase of a pixel.
// Depends on cpb_pkg for the stage word and phase codes.
module cpb_colour (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  cpb_pkg::t_stage        i_st,
    input  logic [7:0]             i_len,
    output logic [7:0]             o_red,
    output logic [7:0]             o_green,
    output logic [7:0]             o_blue,
    output logic [7:0]             o_white,
    output logic [1:0]             o_phase
);
    import cpb_pkg::*;

    logic [7:0] r_red, r_green, r_blue, r_white;
    t_phase     r_phase;
    logic [7:0] n_red, n_green, n_blue, n_white;
    t_phase     n_phase;
    logic [5:0] quarter;
    logic [8:0] q1, q2, q3x, q4;
    logic [7:0] marker;

    assign quarter = i_len[7:2];
    assign q1      = {3'b0, quarter};
    assign q2      = {2'b0, quarter, 1'b0};
    assign q3x     = q1 + q2;
    assign q4      = {1'b0, quarter, 2'b0};
    assign marker  = i_len - i_st.q3;

    always_comb begin
        n_red   = 8'd0;
        n_green = 8'd0;
        n_blue  = 8'd0;
        n_white = 8'd0;
        if (i_st.pre) begin
            n_phase = PH_BLINK;
            if (i_st.px < i_len && i_st.blink) begin
                n_red   = 8'd255;
                n_white = 8'd255;
            end
        end else if (i_st.fin) begin
            n_phase = PH_DONE;
        end else begin
            n_phase = PH_BAR;
            if (i_st.px < i_len) begin
                if (i_st.px <= i_st.lit) begin
                    if ({1'b0, i_st.px} < q1) begin
                        n_red = 8'd255;
                    end else if ({1'b0, i_st.px} < q2) begin
                        n_green = 8'd255;
                    end else if ({1'b0, i_st.px} < q3x) begin
                        n_blue = 8'd255;
                    end else if ({1'b0, i_st.px} < q4) begin
                        n_red   = 8'd255;
                        n_green = 8'd255;
                    end else begin
                        n_red   = 8'd138;
                        n_green = 8'd43;
                        n_blue  = 8'd226;
                        n_white = 8'd255;
                    end
                end else if (i_st.px == marker) begin
                    n_red   = 8'd138;
                    n_green = 8'd43;
                    n_blue  = 8'd226;
                    n_white = 8'd255;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
            r_white <= n_white;
            r_phase <= n_phase;
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;
    assign o_white = r_white;
    assign o_phase = r_phase;

endmodule

/* bench/cpb_checker.sv */
// Checker for countdown_progress_bar_pixel: watches config, input and output channels,
// predicts each pixel colour and phase and compares them. Depends on cpb_pkg.
module cpb_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_elapsed_ms,
    input  logic [7:0]  i_pixel_index,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_white,
    input  logic [1:0]  i_phase,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [11:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import cpb_pkg::*;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] w;
        t_phase     ph;
    } t_pixel;

    t_pixel      colour_q[$];
    logic [11:0] dur_secs;
    logic [7:0]  strip_len;

    assign o_pending = colour_q.size();

    function automatic t_pixel pixel_colour(logic [31:0] e, logic [7:0] px);
        t_pixel      c;
        longint unsigned len, total, t, lit, rest, marker, lot;
        len   = strip_len;
        total = (dur_secs == 0 ? DEF_SECONDS : dur_secs) * 1000;
        if (len < MIN_PIXELS) len = MIN_PIXELS;
        c = '{8'd0, 8'd0, 8'd0, 8'd0, PH_BLINK};
        if (e < PRE_MS) begin
            if (px < len && (e % SEC_MS) < BLINK_MS) begin
                c.r = 8'hFF;
                c.w = 8'hFF;
            end
            return c;
        end
        t = e - PRE_MS;
        if (t >= total) begin
            c.ph = PH_DONE;
            return c;
        end
        c.ph = PH_BAR;
        if (px >= len) return c;
        lit    = t * len / total;
        rest   = (t * len - lit * total) / len;
        marker = len - rest * len * (len - lit) / total;
        if (px <= lit) begin
            lot = px / (len / 4);
            case (lot)
                0: c.r = 8'd255;
                1: c.g = 8'd255;
                2: c.b = 8'd255;
                3: begin c.r = 8'd255; c.g = 8'd255; end
                default: begin c.r = 8'd138; c.g = 8'd43; c.b = 8'd226; c.w = 8'd255; end
            endcase
        end else if (px == marker) begin
            c.r = 8'd138; c.g = 8'd43; c.b = 8'd226; c.w = 8'd255;
        end
        return c;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            dur_secs  <= 12'd60;
            strip_len <= 8'd60;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_DURATION) dur_secs <= i_cfg_data;
                else strip_len <= i_cfg_data[7:0];
            end
            if (i_in_valid && i_in_ready)
                colour_q.push_back(pixel_colour(i_elapsed_ms, i_pixel_index));
            if (i_out_valid && i_out_ready) begin
                if (colour_q.size() == 0) begin
                    $display("%0t: result word with nothing expected", $realtime);
                    o_errors++;
                end else begin
                    want = colour_q.pop_front();
                    if (i_red != want.r)   report_mismatch("red", i_red, want.r);
                    if (i_green != want.g) report_mismatch("green", i_green, want.g);
                    if (i_blue != want.b)  report_mismatch("blue", i_blue, want.b);
                    if (i_white != want.w) report_mismatch("white", i_white, want.w);
                    if (i_phase != want.ph) report_mismatch("phase", i_phase, want.ph);
                end
            end
        end
    end
endmodule

/* bench/tb_top.sv */
// Testbench top for countdown_progress_bar_pixel: drives config and pixel words, stalls
// the output side, and gives the verdict. Depends on cpb_pkg, cpb_checker and countdown_progress_bar_pixel.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cpb_pkg::*;

    localparam int DRAIN = 60;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_elapsed_ms = '0;
    logic [7:0]  i_pixel_index = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_red, o_green, o_blue, o_white;
    logic [1:0]  o_phase;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [11:0] i_cfg_data = '0;
    int          errors, pending;
    bit          calm = 1'b0;      // no idling in the last part
    bit          hold_off = 1'b0;  // long receiver stall request
    logic [11:0] cur_secs = 12'd60;
    logic [7:0]  cur_len = 8'd60;

    always #6 i_clk = ~i_clk;

    countdown_progress_bar_pixel DUT (.*);

    cpb_checker u_check (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_elapsed_ms,
        .i_pixel_index, .i_out_valid(o_out_valid), .i_out_ready, .i_red(o_red),
        .i_green(o_green), .i_blue(o_blue), .i_white(o_white), .i_phase(o_phase),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_out_ready <= 1'b0;
                repeat (200) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                i_out_ready <= 1'b0;
                n = $urandom_range(1, 17);
                repeat (n) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    // leaves the write channel valid; the caller drops it after the last write
    task automatic write_reg(t_cfg_idx idx, logic [11:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_DURATION) cur_secs = val;
        else cur_len = val[7:0];
    endtask

    task automatic wait_drained();
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic send_pixel(logic [31:0] e, logic [7:0] px);
        int n;
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            n = $urandom_range(1, 17);
            repeat (n) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_elapsed_ms  <= e;
        i_pixel_index <= px;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    function automatic logic [31:0] pick_time();
        int unsigned total, k;
        total = (cur_secs == 0 ? 60 : cur_secs) * 1000;
        k = $urandom_range(0, 9);
        if (k < 2) return $urandom_range(0, PRE_MS - 1);
        if (k < 8) return PRE_MS + $urandom_range(0, total - 1);
        if (k == 8) return PRE_MS + total + $urandom_range(0, 3);
        return $urandom;
    endfunction

    function automatic logic [7:0] pick_pixel();
        int unsigned len;
        len = cur_len < 4 ? 4 : cur_len;
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 254);
        return $urandom_range(0, len - 1);
    endfunction

    initial begin
        #100ms;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        logic [11:0] secs_set[6] = '{12'd0, 12'd1, 12'd3600, 12'd7, 12'd60, 12'd4095};
        logic [11:0] len_set[6]  = '{12'd0, 12'd255, 12'd4, 12'd13, 12'd60, 12'd3};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: blink edges, phase boundaries, extremes of fields
        send_pixel(32'd0, 8'd0);
        send_pixel(32'd499, 8'd59);
        send_pixel(32'd500, 8'd0);
        send_pixel(32'd9999, 8'd60);
        send_pixel(32'd9499, 8'd254);
        send_pixel(32'd10000, 8'd0);
        send_pixel(32'd10000, 8'd59);
        send_pixel(32'd39999, 8'd29);
        send_pixel(32'd69999, 8'd59);
        send_pixel(32'd69999, 8'd58);
        send_pixel(32'd70000, 8'd0);
        send_pixel(32'hFFFF_FFFF, 8'hFF);
        send_pixel(32'h5555_5555, 8'hAA);
        send_pixel(32'd25000, 8'd55);
        // hold the output off while words keep coming so the pipe fills
        hold_off = 1'b1;
        for (int i = 0; i < 100; i++) send_pixel(pick_time(), pick_pixel());
        i_in_valid <= 1'b0;
        wait_drained();

        for (int s = 0; s < 6; s++) begin
            write_reg(CFG_DURATION, secs_set[s]);
            write_reg(CFG_LENGTH, len_set[s]);
            i_cfg_valid <= 1'b0;
            if (s == 5) calm = 1'b1;
            for (int i = 0; i < 175; i++) send_pixel(pick_time(), pick_pixel());
            // 13 pixels: lit pixels past the fourth quarter show purple
            if (s == 3) send_pixel(PRE_MS + 6999, 8'd12);
            i_in_valid <= 1'b0;
            wait_drained();
        end

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
